[rtl/core/cktc_pkg.sv]
// Shared types and constants of the countdown kitchen timer controller.
// Used by cktc_step and countdown_kitchen_timer_control_unit; depends on nothing.
package cktc_pkg;

    localparam int SEC_W = 13;
    localparam int CNT_W = 7;
    localparam int DATA_W = 13;
    localparam int IDX_W = 3;

    localparam logic [3:0] ALARM_REPEATS = 4'd4;

    // event codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_MELODY = 2'd2;

    // display modes
    localparam logic [1:0] MODE_CLOCK   = 2'd0;
    localparam logic [1:0] MODE_SETTING = 2'd1;
    localparam logic [1:0] MODE_ALARM   = 2'd2;
    localparam logic [1:0] MODE_SLEEP   = 2'd3;

    // run states
    localparam logic [1:0] RUN_STOP = 2'd0;
    localparam logic [1:0] RUN_DUE  = 2'd1;
    localparam logic [1:0] RUN_WAIT = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TICKS_PER_SECOND = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLEEP_SECONDS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIM_SECONDS      = 3'd2;
    localparam logic [IDX_W-1:0] REG_PRESET_TWO       = 3'd3;
    localparam logic [IDX_W-1:0] REG_PRESET_THREE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PRESET_FOUR      = 3'd5;
    localparam logic [IDX_W-1:0] REG_PRESET_FIVE      = 3'd6;
    localparam logic [IDX_W-1:0] REG_PRESET_SIX       = 3'd7;

    // wrap limits of the edit digits, index 0 is tens of minutes
    localparam logic [3:0][3:0] DIGIT_MAX = {4'd9, 4'd5, 4'd9, 4'd9};

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] buttons;
    } req_t;

    typedef struct packed {
        logic [SEC_W-1:0] remaining;
        logic [1:0]       mode;
        logic             running;
        logic [2:0]       preset_index;
        logic [2:0]       edit_position;
        logic [3:0]       digit_tens_minutes;
        logic [3:0]       digit_minutes;
        logic [2:0]       digit_tens_seconds;
        logic [3:0]       digit_seconds;
        logic             backlight_bright;
        logic             play_melody;
    } rsp_t;

    typedef struct packed {
        logic [CNT_W-1:0]      ticks_per_second;
        logic [CNT_W-1:0]      sleep_seconds;
        logic [CNT_W-1:0]      dim_seconds;
        logic [4:0][SEC_W-1:0] fixed_preset;   // presets two to six
    } cfg_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [1:0]       run;
        logic [SEC_W-1:0] remaining;
        logic [SEC_W-1:0] start;
        logic [SEC_W-1:0] user;
        logic [2:0]       sel;
        logic [1:0]       edit_pos;
        logic [3:0][3:0]  digits;
        logic [3:0]       alarm_left;
        logic [CNT_W-1:0] subsec;
        logic [CNT_W-1:0] sleep_cnt;
        logic [CNT_W-1:0] dim_cnt;
        logic             bright;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        ticks_per_second: 7'd64,
        sleep_seconds:    7'd30,
        dim_seconds:      7'd10,
        fixed_preset:     {13'd2580, 13'd900, 13'd600, 13'd570, 13'd210}
    };

    localparam state_t STATE_RESET = '{
        mode:       MODE_CLOCK,
        run:        RUN_STOP,
        remaining:  13'd210,
        start:      13'd210,
        user:       13'd0,
        sel:        3'd2,
        edit_pos:   2'd0,
        digits:     16'd0,
        alarm_left: ALARM_REPEATS,
        subsec:     7'd64,
        sleep_cnt:  7'd30,
        dim_cnt:    7'd10,
        bright:     1'b1
    };

endpackage

[rtl/core/cktc_step.sv]
// Next-state and status logic for one timer event.
// Purely combinational; depends on cktc_pkg.
module cktc_step (
    input  cktc_pkg::state_t state,
    input  cktc_pkg::req_t   evt,
    input  cktc_pkg::cfg_t   cfg,
    output cktc_pkg::state_t state_next,
    output cktc_pkg::rsp_t   result
);

    cktc_pkg::state_t n;
    logic [1:0]       pos;
    logic [3:0]       cur;
    logic [3:0]       mx;
    logic [cktc_pkg::SEC_W-1:0] digit_sum;

    function automatic logic [cktc_pkg::SEC_W-1:0] preset_value(
        input logic [2:0]                 sel,
        input logic [cktc_pkg::SEC_W-1:0] user,
        input cktc_pkg::cfg_t             c
    );
        logic [cktc_pkg::SEC_W-1:0] v;
        v = user;
        if (sel >= 3'd2 && sel <= 3'd6)
        begin
            v = c.fixed_preset[3'(sel - 3'd2)];
        end
        return v;
    endfunction

    assign pos = state.edit_pos;
    assign cur = state.digits[pos];
    assign mx  = cktc_pkg::DIGIT_MAX[pos];

    assign digit_sum = 13'(state.digits[0]) * 13'd600 + 13'(state.digits[1]) * 13'd60
                     + 13'(state.digits[2]) * 13'd10 + 13'(state.digits[3]);

    always_comb
    begin
        n = state;
        unique case (evt.cmd)
            cktc_pkg::CMD_TICK:
            begin
                if (n.mode != cktc_pkg::MODE_SLEEP)
                begin
                    if (n.subsec > 7'd1)
                    begin
                        n.subsec = n.subsec - 7'd1;
                    end
                    else
                    begin
                        // one second elapsed
                        n.subsec = cfg.ticks_per_second;
                        if (n.run == cktc_pkg::RUN_WAIT)
                        begin
                            n.run = cktc_pkg::RUN_DUE;
                        end
                        if (n.mode == cktc_pkg::MODE_CLOCK)
                        begin
                            if (n.dim_cnt != '0)
                            begin
                                n.dim_cnt = n.dim_cnt - 7'd1;
                            end
                            if (n.dim_cnt == '0)
                            begin
                                n.bright = 1'b0;
                            end
                            if (n.run == cktc_pkg::RUN_STOP)
                            begin
                                if (n.sleep_cnt != '0)
                                begin
                                    n.sleep_cnt = n.sleep_cnt - 7'd1;
                                end
                                if (n.sleep_cnt == '0)
                                begin
                                    n.mode = cktc_pkg::MODE_SLEEP;
                                end
                            end
                        end
                    end
                end
            end
            cktc_pkg::CMD_BUTTON:
            begin
                n.dim_cnt = cfg.dim_seconds;
                n.bright  = 1'b1;
                unique case (state.mode)
                    cktc_pkg::MODE_CLOCK:
                    begin
                        // lowest pressed button wins
                        priority if (evt.buttons[0])
                        begin
                            if (n.run == cktc_pkg::RUN_STOP)
                            begin
                                n.run    = cktc_pkg::RUN_DUE;
                                n.subsec = cfg.ticks_per_second;
                            end
                            else
                            begin
                                n.run = cktc_pkg::RUN_STOP;
                            end
                        end
                        else if (evt.buttons[1])
                        begin
                            n.sel = (n.sel <= 3'd1 || n.sel > 3'd6) ? 3'd6 : n.sel - 3'd1;
                            n.start     = preset_value(n.sel, n.user, cfg);
                            n.remaining = n.start;
                        end
                        else if (evt.buttons[2])
                        begin
                            n.sel = (n.sel >= 3'd6 || n.sel < 3'd1) ? 3'd1 : n.sel + 3'd1;
                            n.start     = preset_value(n.sel, n.user, cfg);
                            n.remaining = n.start;
                        end
                        else if (evt.buttons[3])
                        begin
                            n.mode     = cktc_pkg::MODE_SETTING;
                            n.edit_pos = 2'd0;
                        end
                        else
                        begin
                        end
                    end
                    cktc_pkg::MODE_ALARM:
                    begin
                        n.mode       = cktc_pkg::MODE_CLOCK;
                        n.run        = cktc_pkg::RUN_STOP;
                        n.alarm_left = cktc_pkg::ALARM_REPEATS;
                    end
                    cktc_pkg::MODE_SETTING:
                    begin
                        priority if (evt.buttons[0])
                        begin
                            n.edit_pos = pos + 2'd1;
                        end
                        else if (evt.buttons[1])
                        begin
                            n.digits[pos] = (cur >= mx) ? 4'd0 : cur + 4'd1;
                        end
                        else if (evt.buttons[2])
                        begin
                            n.digits[pos] = (cur == 4'd0 || cur > mx) ? mx : cur - 4'd1;
                        end
                        else if (evt.buttons[3])
                        begin
                            n.user      = digit_sum;
                            n.sel       = 3'd1;
                            n.start     = digit_sum;
                            n.remaining = digit_sum;
                            n.mode      = cktc_pkg::MODE_CLOCK;
                        end
                        else
                        begin
                        end
                    end
                    default:
                    begin
                        // wake from sleep
                        n.mode      = cktc_pkg::MODE_CLOCK;
                        n.start     = preset_value(n.sel, n.user, cfg);
                        n.remaining = n.start;
                        n.sleep_cnt = cfg.sleep_seconds;
                    end
                endcase
            end
            cktc_pkg::CMD_MELODY:
            begin
                if (n.mode == cktc_pkg::MODE_ALARM)
                begin
                    if (n.alarm_left <= 4'd1)
                    begin
                        n.mode       = cktc_pkg::MODE_CLOCK;
                        n.run        = cktc_pkg::RUN_STOP;
                        n.alarm_left = cktc_pkg::ALARM_REPEATS;
                    end
                    else
                    begin
                        n.alarm_left = n.alarm_left - 4'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (n.mode == cktc_pkg::MODE_CLOCK && n.run == cktc_pkg::RUN_DUE)
        begin
            if (n.remaining != '0)
            begin
                n.remaining = n.remaining - 13'd1;
            end
            if (n.remaining == '0)
            begin
                n.remaining = n.start;
                n.mode      = cktc_pkg::MODE_ALARM;
                n.run       = cktc_pkg::RUN_STOP;
            end
            else
            begin
                n.run = cktc_pkg::RUN_WAIT;
            end
        end

        if (n.mode == cktc_pkg::MODE_SETTING || n.mode == cktc_pkg::MODE_ALARM)
        begin
            n.sleep_cnt = cfg.sleep_seconds;
            n.dim_cnt   = cfg.dim_seconds;
        end
        else if (n.mode == cktc_pkg::MODE_CLOCK && n.run != cktc_pkg::RUN_STOP)
        begin
            n.sleep_cnt = cfg.sleep_seconds;
        end
    end

    assign state_next = n;

    always_comb
    begin
        result.remaining          = n.remaining;
        result.mode               = n.mode;
        result.running            = (n.run != cktc_pkg::RUN_STOP);
        result.preset_index       = n.sel;
        result.edit_position      = {1'b0, n.edit_pos} + 3'd1;
        result.digit_tens_minutes = n.digits[0];
        result.digit_minutes      = n.digits[1];
        result.digit_tens_seconds = n.digits[2][2:0];
        result.digit_seconds      = n.digits[3];
        result.backlight_bright   = n.bright;
        result.play_melody        = (n.mode == cktc_pkg::MODE_ALARM);
    end

endmodule

[rtl/core/countdown_kitchen_timer_control_unit.sv]
// Top level of the countdown kitchen timer controller: event register,
// timer state, configuration registers and status register. Uses cktc_pkg, cktc_step.
//
//  channel  dir  handshake            payload
//  req      in   req_valid/req_ready   cktc_pkg::req_t  (cmd, buttons)
//  rsp      out  rsp_valid/rsp_ready   cktc_pkg::rsp_t  (status)
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// One event per cycle while rsp is not stalled: an accepted event is registered,
// then applied to the timer state when the status register can advance, which
// also loads the status register and raises rsp_valid.
// The event register takes a new transaction while the status register waits,
// so a stalled rsp backs up into req after one more event.
// Reset restores the timer state, the configuration registers and both valid flags.
module countdown_kitchen_timer_control_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  cktc_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output cktc_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [cktc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [cktc_pkg::DATA_W-1:0]         cfg_data
);

    cktc_pkg::cfg_t   cfg_reg;
    cktc_pkg::state_t state_reg;
    cktc_pkg::state_t state_next;
    cktc_pkg::req_t   evt_reg;
    logic             evt_valid_reg;
    cktc_pkg::rsp_t   rsp_reg;
    cktc_pkg::rsp_t   rsp_next;
    logic             rsp_valid_reg;
    logic             advance;
    logic             fire;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign fire      = evt_valid_reg && advance;
    assign req_ready = !evt_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    cktc_step u_step (
        .state      (state_reg),
        .evt        (evt_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cktc_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cktc_pkg::REG_TICKS_PER_SECOND:
                    cfg_reg.ticks_per_second <= cfg_data[cktc_pkg::CNT_W-1:0];
                cktc_pkg::REG_SLEEP_SECONDS:
                    cfg_reg.sleep_seconds <= cfg_data[cktc_pkg::CNT_W-1:0];
                cktc_pkg::REG_DIM_SECONDS:
                    cfg_reg.dim_seconds <= cfg_data[cktc_pkg::CNT_W-1:0];
                cktc_pkg::REG_PRESET_TWO:
                    cfg_reg.fixed_preset[0] <= cfg_data;
                cktc_pkg::REG_PRESET_THREE:
                    cfg_reg.fixed_preset[1] <= cfg_data;
                cktc_pkg::REG_PRESET_FOUR:
                    cfg_reg.fixed_preset[2] <= cfg_data;
                cktc_pkg::REG_PRESET_FIVE:
                    cfg_reg.fixed_preset[3] <= cfg_data;
                cktc_pkg::REG_PRESET_SIX:
                    cfg_reg.fixed_preset[4] <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            evt_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            evt_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cktc_pkg::STATE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTH
    // melody request tracks alarm mode
    a_melody_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.play_melody == (rsp_reg.mode == cktc_pkg::MODE_ALARM)))
        else $error("play_melody disagrees with alarm mode");

    // countdown never runs in alarm or sleep mode
    a_no_run_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.mode == cktc_pkg::MODE_ALARM
                           || rsp_reg.mode == cktc_pkg::MODE_SLEEP)) |-> !rsp_reg.running)
        else $error("countdown running in alarm or sleep mode");

    // edit digits stay inside their wrap limits
    a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digits[0] <= cktc_pkg::DIGIT_MAX[0]
        && state_reg.digits[1] <= cktc_pkg::DIGIT_MAX[1]
        && state_reg.digits[2] <= cktc_pkg::DIGIT_MAX[2]
        && state_reg.digits[3] <= cktc_pkg::DIGIT_MAX[3])
        else $error("edit digit out of range");

    // selected preset is always one of six
    a_preset_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sel >= 3'd1 && state_reg.sel <= 3'd6)
        else $error("preset index out of range");

    // a stalled event waits in the event register without being applied
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid_reg && !advance) |=> (evt_valid_reg && $stable(evt_reg)
                                         && $stable(state_reg)))
        else $error("stalled event lost or state changed");
`endif

endmodule

[sim/tb_countdown_kitchen_timer_control_unit.sv]
// Self-checking testbench for countdown_kitchen_timer_control_unit: a directed event script,
// then random event phases under several register settings, each checked by an internal model.
// Depends on cktc_pkg and the RTL of the timer controller.
module tb_countdown_kitchen_timer_control_unit;

    import cktc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 7;
    localparam int EVENTS_PER_PHASE = 205;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [3:0] BTN_NONE  = 4'b0000;
    localparam logic [3:0] BTN_START = 4'b0001;
    localparam logic [3:0] BTN_LEFT  = 4'b0010;
    localparam logic [3:0] BTN_RIGHT = 4'b0100;
    localparam logic [3:0] BTN_SET   = 4'b1000;
    localparam logic [3:0] BTN_ALL   = 4'b1111;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY, RX_CADENCE} rx_style_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] buttons;
        logic       fixed;      // compare against the reset status below
    } script_row_t;

    localparam rsp_t RESET_STATUS = '{
        remaining:          13'd210,
        mode:               MODE_CLOCK,
        running:            1'b0,
        preset_index:       3'd2,
        edit_position:      3'd1,
        digit_tens_minutes: 4'd0,
        digit_minutes:      4'd0,
        digit_tens_seconds: 3'd0,
        digit_seconds:      4'd0,
        backlight_bright:   1'b1,
        play_melody:        1'b0
    };

    // runs with every tick a full second, short idle timers and presets from 0 to 8191
    localparam int SCRIPT_LEN = 28;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{CMD_TICK,   BTN_ALL,   1'b1},  // tick with all bits set, buttons ignored
        '{CMD_UNUSED, BTN_START, 1'b1},
        '{CMD_MELODY, BTN_NONE,  1'b1},  // melody end outside alarm
        '{CMD_BUTTON, BTN_NONE,  1'b1},  // press with no bit set
        '{CMD_BUTTON, BTN_START, 1'b0},  // start takes a second off at once
        '{CMD_BUTTON, BTN_RIGHT, 1'b0},  // preset change while running, lands on zero
        '{CMD_TICK,   BTN_NONE,  1'b0},  // zero reached -> alarm, dims
        '{CMD_MELODY, BTN_NONE,  1'b0},
        '{CMD_BUTTON, BTN_ALL,   1'b0},  // alarm stop, any pressed button ends it
        '{CMD_BUTTON, BTN_LEFT,  1'b0},
        '{CMD_TICK,   BTN_NONE,  1'b0},
        '{CMD_TICK,   BTN_NONE,  1'b0},  // sleep
        '{CMD_TICK,   BTN_NONE,  1'b0},  // ignored while asleep
        '{CMD_BUTTON, BTN_SET,   1'b0},  // wake
        '{CMD_BUTTON, BTN_SET,   1'b0},  // enter setting
        '{CMD_BUTTON, BTN_LEFT,  1'b0},
        '{CMD_BUTTON, BTN_START, 1'b0},
        '{CMD_BUTTON, BTN_RIGHT, 1'b0},  // digit wraps down to nine
        '{CMD_BUTTON, BTN_START, 1'b0},
        '{CMD_BUTTON, BTN_RIGHT, 1'b0},  // tens of seconds wraps down to five
        '{CMD_BUTTON, BTN_START, 1'b0},
        '{CMD_BUTTON, BTN_LEFT,  1'b0},
        '{CMD_BUTTON, BTN_START, 1'b0},  // position wraps to first digit
        '{CMD_BUTTON, BTN_SET,   1'b0},  // store user preset
        '{CMD_BUTTON, BTN_START, 1'b0},
        '{CMD_BUTTON, BTN_SET,   1'b0},  // setting entered while running
        '{CMD_TICK,   BTN_NONE,  1'b0},
        '{CMD_BUTTON, BTN_SET,   1'b0}   // back to clock, pending second taken
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    countdown_kitchen_timer_control_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // timer model: configuration and state
    int unsigned c_tps, c_sleep, c_dim;
    int unsigned c_preset [5];
    logic [1:0]  t_mode, t_run;
    int unsigned t_remaining, t_start, t_user, t_sel, t_pos, t_alarm_left;
    int unsigned t_subsec, t_sleep, t_dim;
    int unsigned t_digit [4];
    bit          t_bright;
    int unsigned digit_top [4] = '{9, 9, 5, 9};

    rsp_t        status_due [$];
    rsp_t        want_status;
    logic [12:0] reg_plan [8];
    int          error_count = 0;
    int          status_count = 0;
    int          cycle_count = 0;
    int          rx_cycle = 0;
    int          rx_hold = 0;
    rx_style_t   rx_mode = RX_OPEN;

    task automatic flag_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("status %0d field %s: got %0d expected %0d",
                                 status_count, name, got, want));
    endtask

    function automatic int unsigned preset_secs(input int unsigned sel);
        if (sel >= 2 && sel <= 6)
            return c_preset[sel - 2] & 32'h1FFF;
        return t_user & 32'h1FFF;
    endfunction

    task automatic reload_from_preset();
        t_start = preset_secs(t_sel);
        t_remaining = t_start;
    endtask

    task automatic return_to_clock();
        t_mode = MODE_CLOCK;
        t_run = RUN_STOP;
        t_alarm_left = ALARM_REPEATS;
    endtask

    task automatic second_elapsed();
        if (t_run == RUN_WAIT)
            t_run = RUN_DUE;
        if (t_mode == MODE_CLOCK) begin
            if (t_dim > 0)
                t_dim--;
            if (t_dim == 0)
                t_bright = 1'b0;
            if (t_run == RUN_STOP) begin
                if (t_sleep > 0)
                    t_sleep--;
                if (t_sleep == 0)
                    t_mode = MODE_SLEEP;
            end
        end
    endtask

    task automatic clock_press(input logic [3:0] b);
        if (b[0]) begin
            if (t_run == RUN_STOP) begin
                t_run = RUN_DUE;
                t_subsec = c_tps;
            end else begin
                t_run = RUN_STOP;
            end
        end else if (b[1]) begin
            t_sel = (t_sel <= 1 || t_sel > 6) ? 6 : t_sel - 1;
            reload_from_preset();
        end else if (b[2]) begin
            t_sel = (t_sel >= 6 || t_sel < 1) ? 1 : t_sel + 1;
            reload_from_preset();
        end else if (b[3]) begin
            t_mode = MODE_SETTING;
            t_pos = 0;
        end
    endtask

    task automatic setting_press(input logic [3:0] b);
        int unsigned p;
        int unsigned top;
        p = t_pos & 3;
        top = digit_top[p];
        if (b[0]) begin
            t_pos = (p + 1) & 3;
        end else if (b[1]) begin
            t_digit[p] = (t_digit[p] >= top) ? 0 : t_digit[p] + 1;
        end else if (b[2]) begin
            t_digit[p] = (t_digit[p] == 0 || t_digit[p] > top) ? top : t_digit[p] - 1;
        end else if (b[3]) begin
            t_user = t_digit[0] * 600 + t_digit[1] * 60 + t_digit[2] * 10 + t_digit[3];
            t_sel = 1;
            reload_from_preset();
            t_mode = MODE_CLOCK;
        end
    endtask

    // applies one event to the model and returns the status it produces
    task automatic advance_timer(input req_t ev, output rsp_t st);
        case (ev.cmd)
            CMD_TICK: begin
                if (t_mode != MODE_SLEEP) begin
                    if (t_subsec > 1) begin
                        t_subsec--;
                    end else begin
                        t_subsec = c_tps;
                        second_elapsed();
                    end
                end
            end
            CMD_BUTTON: begin
                t_dim = c_dim;
                t_bright = 1'b1;
                if (t_mode == MODE_CLOCK) begin
                    clock_press(ev.buttons);
                end else if (t_mode == MODE_ALARM) begin
                    return_to_clock();
                end else if (t_mode == MODE_SETTING) begin
                    setting_press(ev.buttons);
                end else begin
                    t_mode = MODE_CLOCK;
                    reload_from_preset();
                    t_sleep = c_sleep;
                end
            end
            CMD_MELODY: begin
                if (t_mode == MODE_ALARM) begin
                    if (t_alarm_left <= 1)
                        return_to_clock();
                    else
                        t_alarm_left--;
                end
            end
            default: ;
        endcase

        if (t_mode == MODE_CLOCK && t_run == RUN_DUE) begin
            t_remaining = (t_remaining > 0) ? t_remaining - 1 : 0;
            if (t_remaining == 0) begin
                t_remaining = t_start;
                t_mode = MODE_ALARM;
                t_run = RUN_STOP;
            end else begin
                t_run = RUN_WAIT;
            end
        end
        if (t_mode == MODE_SETTING || t_mode == MODE_ALARM) begin
            t_sleep = c_sleep;
            t_dim = c_dim;
        end else if (t_mode == MODE_CLOCK && t_run != RUN_STOP) begin
            t_sleep = c_sleep;
        end

        st.remaining          = SEC_W'(t_remaining);
        st.mode               = t_mode;
        st.running            = (t_run != RUN_STOP);
        st.preset_index       = 3'(t_sel);
        st.edit_position      = 3'((t_pos & 3) + 1);
        st.digit_tens_minutes = 4'(t_digit[0]);
        st.digit_minutes      = 4'(t_digit[1]);
        st.digit_tens_seconds = 3'(t_digit[2]);
        st.digit_seconds      = 4'(t_digit[3]);
        st.backlight_bright   = t_bright;
        st.play_melody        = (t_mode == MODE_ALARM);
    endtask

    // called at a falling edge while the block is idle; returns at a falling edge
    task automatic program_timer();
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data <= reg_plan[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        c_tps = reg_plan[REG_TICKS_PER_SECOND][CNT_W-1:0];
        c_sleep = reg_plan[REG_SLEEP_SECONDS][CNT_W-1:0];
        c_dim = reg_plan[REG_DIM_SECONDS][CNT_W-1:0];
        c_preset[0] = reg_plan[REG_PRESET_TWO];
        c_preset[1] = reg_plan[REG_PRESET_THREE];
        c_preset[2] = reg_plan[REG_PRESET_FOUR];
        c_preset[3] = reg_plan[REG_PRESET_FIVE];
        c_preset[4] = reg_plan[REG_PRESET_SIX];
    endtask

    // drives one event and waits for the transaction; returns at a falling edge
    task automatic send_event(input req_t ev, input bit fixed);
        rsp_t predicted;
        req_valid <= 1'b1;
        req <= ev;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        advance_timer(ev, predicted);
        status_due.push_back(fixed ? RESET_STATUS : predicted);
        @(negedge clk);
    endtask

    task automatic drain_statuses();
        req_valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d statuses pending",
                     cycle_count, status_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
                flag_error("status transaction with no event pending");
            end else begin
                want_status = status_due.pop_front();
                check_field("remaining", 16'(rsp.remaining), 16'(want_status.remaining));
                check_field("mode", 16'(rsp.mode), 16'(want_status.mode));
                check_field("running", 16'(rsp.running), 16'(want_status.running));
                check_field("preset_index", 16'(rsp.preset_index),
                            16'(want_status.preset_index));
                check_field("edit_position", 16'(rsp.edit_position),
                            16'(want_status.edit_position));
                check_field("digit_tens_minutes", 16'(rsp.digit_tens_minutes),
                            16'(want_status.digit_tens_minutes));
                check_field("digit_minutes", 16'(rsp.digit_minutes),
                            16'(want_status.digit_minutes));
                check_field("digit_tens_seconds", 16'(rsp.digit_tens_seconds),
                            16'(want_status.digit_tens_seconds));
                check_field("digit_seconds", 16'(rsp.digit_seconds),
                            16'(want_status.digit_seconds));
                check_field("backlight_bright", 16'(rsp.backlight_bright),
                            16'(want_status.backlight_bright));
                check_field("play_melody", 16'(rsp.play_melody),
                            16'(want_status.play_melody));
            end
            status_count++;
        end
    end

    // status sink: switches between open, random, bursty and fixed-cadence stalls
    always @(negedge clk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_mode = rx_style_t'($urandom_range(0, 3));
        if (rx_hold != 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   rsp_ready <= 1'b1;
                RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
                RX_BURSTY: begin
                    rsp_ready <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        rx_hold = $urandom_range(1, 12);
                end
                default:   rsp_ready <= (rx_cycle % 3 != 0);
            endcase
        end
    end

    initial begin
        req_t ev;
        int   burst_left;
        int   roll;

        c_tps = 64;
        c_sleep = 30;
        c_dim = 10;
        c_preset = '{210, 570, 600, 900, 2580};
        t_mode = MODE_CLOCK;
        t_run = RUN_STOP;
        t_remaining = 210;
        t_start = 210;
        t_user = 0;
        t_sel = 2;
        t_pos = 0;
        t_digit = '{0, 0, 0, 0};
        t_alarm_left = ALARM_REPEATS;
        t_subsec = 64;
        t_sleep = 30;
        t_dim = 10;
        t_bright = 1'b1;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero ticks per second: every tick is a full second
        reg_plan[REG_TICKS_PER_SECOND] = 13'd0;
        reg_plan[REG_SLEEP_SECONDS]    = 13'd2;
        reg_plan[REG_DIM_SECONDS]      = 13'd1;
        reg_plan[REG_PRESET_TWO]       = 13'd3;
        reg_plan[REG_PRESET_THREE]     = 13'd0;
        reg_plan[REG_PRESET_FOUR]      = 13'd8191;
        reg_plan[REG_PRESET_FIVE]      = 13'd5999;
        reg_plan[REG_PRESET_SIX]       = 13'd1;
        program_timer();

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            ev.cmd = SCRIPT[i].cmd;
            ev.buttons = SCRIPT[i].buttons;
            send_event(ev, SCRIPT[i].fixed);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_statuses();
            case (ph)
                1: begin
                    reg_plan[REG_TICKS_PER_SECOND] = 13'd0;
                    reg_plan[REG_SLEEP_SECONDS]    = 13'd0;
                    reg_plan[REG_DIM_SECONDS]      = 13'd0;
                    for (int r = REG_PRESET_TWO; r <= REG_PRESET_SIX; r++)
                        reg_plan[r] = 13'($urandom_range(0, 5));
                end
                2: begin
                    reg_plan[REG_TICKS_PER_SECOND] = 13'd127;
                    reg_plan[REG_SLEEP_SECONDS]    = 13'd127;
                    reg_plan[REG_DIM_SECONDS]      = 13'd127;
                    reg_plan[REG_PRESET_TWO]       = 13'd5999;
                    reg_plan[REG_PRESET_THREE]     = 13'd8191;
                    reg_plan[REG_PRESET_FOUR]      = 13'd0;
                    reg_plan[REG_PRESET_FIVE]      = 13'd6000;
                    reg_plan[REG_PRESET_SIX]       = 13'd1;
                end
                3: begin
                    reg_plan[REG_TICKS_PER_SECOND] = 13'd1;
                    reg_plan[REG_SLEEP_SECONDS]    = 13'd127;
                    reg_plan[REG_DIM_SECONDS]      = 13'd1;
                    for (int r = REG_PRESET_TWO; r <= REG_PRESET_SIX; r++)
                        reg_plan[r] = 13'($urandom_range(0, 8191));
                end
                default: begin
                    // junk above bit 6 of the short registers must be dropped
                    reg_plan[REG_TICKS_PER_SECOND] = {6'($urandom), 7'($urandom_range(1, 3))};
                    reg_plan[REG_SLEEP_SECONDS]    = {6'($urandom), 7'($urandom_range(1, 4))};
                    reg_plan[REG_DIM_SECONDS]      = {6'($urandom), 7'($urandom_range(1, 4))};
                    for (int r = REG_PRESET_TWO; r <= REG_PRESET_SIX; r++)
                        reg_plan[r] = 13'($urandom_range(0, 12));
                end
            endcase
            program_timer();

            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 2) == 0)
                    ev.buttons = 4'($urandom_range(0, 15));
                else
                    ev.buttons = 4'(1 << $urandom_range(0, 3));
                if (t_mode == MODE_ALARM && roll < 45)
                    ev.cmd = CMD_MELODY;
                else if (t_mode == MODE_SLEEP && roll < 25)
                    ev.cmd = CMD_BUTTON;
                else if (roll < 60)
                    ev.cmd = CMD_TICK;
                else if (roll < 88)
                    ev.cmd = CMD_BUTTON;
                else if (roll < 97)
                    ev.cmd = CMD_MELODY;
                else
                    ev.cmd = CMD_UNUSED;
                send_event(ev, 1'b0);

                burst_left--;
                if (burst_left == 0) begin
                    req_valid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(negedge clk);
                    burst_left = $urandom_range(1, 40);
                end else if ($urandom_range(0, 99) == 0) begin
                    drain_statuses();
                end
            end
        end

        drain_statuses();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
